// ===== rtl/dfr_pkg.sv =====
package dfr_pkg;

    localparam int MaxPayloadBytes = 256;
    localparam int LenW = 9;
    localparam int CntW = 16;
    localparam int TotW = 16;
    localparam int IdxW = 9;
    localparam int CfgW = 16;
    localparam int InDataW = 48;
    localparam int InUserW = 1;
    localparam int OutDataW = 48;

    localparam logic [CntW-1:0] TimeoutReset = 16'd5000;
    localparam logic [TotW-1:0] TotMax = 16'hFFFF;
    localparam logic [CntW-1:0] CntMax = 16'hFFFF;

    localparam logic [7:0] MsgArm = 8'd12;
    localparam logic [7:0] MsgFragStart = 8'd40;
    localparam logic [7:0] MsgFragCont = 8'd41;
    localparam logic [7:0] MsgFragEnd = 8'd42;
    localparam logic [7:0] MsgPaging = 8'd11;
    localparam logic [7:0] MsgSmsAck = 8'd14;
    localparam logic [7:0] MsgSmsNoack = 8'd16;

    localparam logic [0:0] ReqMessage = 1'b0;
    localparam logic [0:0] ReqTick = 1'b1;

    localparam logic [0:0] CfgOwnShipId = 1'b0;
    localparam logic [0:0] CfgTimeoutTicks = 1'b1;

    typedef enum logic [2:0] {
        LINK_UPLINK_ADDR   = 3'd0,
        LINK_BROADCAST     = 3'd1,
        LINK_DOWNLINK_ADDR = 3'd2,
        LINK_PAGING        = 3'd3,
        LINK_SMS_ACK       = 3'd4,
        LINK_SMS_NOACK     = 3'd5
    } t_link;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_BCAST = 2'd1,
        MODE_UCAST = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_IGNORED   = 3'd1,
        EV_STARTED   = 3'd2,
        EV_CONTINUED = 3'd3,
        EV_COMPLETE  = 3'd4,
        EV_EMPTY     = 3'd5,
        EV_SEQERR    = 3'd6,
        EV_TIMEOUT   = 3'd7
    } t_event;

    typedef struct packed {
        logic [0:0]      req_type;
        logic [7:0]      msg_type;
        logic [15:0]     target_id;
        logic [7:0]      first_byte;
        logic [LenW-1:0] payload_len;
    } t_item;

    typedef struct packed {
        logic [2:0]      link_state;
        logic [1:0]      receive_mode;
        logic [2:0]      event_code;
        logic            send_ack;
        logic [15:0]     ack_ship_id;
        logic [TotW-1:0] total_length;
    } t_result;

endpackage

// ===== rtl/downlink_fragment_receiver.sv =====
// An input item is accepted into the input register, then its result is written into the
// result register; a stalled output holds the item in the input register.
// Throughput: one item per cycle unless the output stalls; receiver state updates in a single pass.
// Reset is synchronous and active low; it empties both registers, sets the
// receiver to idle with link state uplink addressing and a timeout of 5000 ticks.
module downlink_fragment_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // msg_type[7:0], target_id[23:8], first_byte[31:24], payload_len[40:32]
    input  logic [dfr_pkg::InDataW-1:0]    s_axis_tdata,
    // req_type[0]
    input  logic [dfr_pkg::InUserW-1:0]    s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // link_state[2:0], receive_mode[4:3], event_code[7:5], send_ack[8],
    // ack_ship_id[24:9], total_length[40:25]
    output logic [dfr_pkg::OutDataW-1:0]   m_axis_tdata,
    input  logic                           i_cfg_wr_en,
    input  logic [0:0]                     i_cfg_index,
    input  logic [dfr_pkg::CfgW-1:0]       i_cfg_wr_data
);

    logic             r_in_valid;
    dfr_pkg::t_item   r_in_item;
    logic             r_out_valid;
    dfr_pkg::t_result r_out_result;
    dfr_pkg::t_result result;
    logic             advance;

    assign advance = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    dfr_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (advance),
        .i_item        (r_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.req_type <= s_axis_tuser[0:0];
            r_in_item.msg_type <= s_axis_tdata[7:0];
            r_in_item.target_id <= s_axis_tdata[23:8];
            r_in_item.first_byte <= s_axis_tdata[31:24];
            r_in_item.payload_len <= s_axis_tdata[40:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_result <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {7'd0,
                           r_out_result.total_length,
                           r_out_result.ack_ship_id,
                           r_out_result.send_ack,
                           r_out_result.event_code,
                           r_out_result.receive_mode,
                           r_out_result.link_state};

endmodule

// ===== rtl/dfr_core.sv =====
module dfr_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  dfr_pkg::t_item             i_item,
    input  logic                       i_cfg_wr_en,
    input  logic [0:0]                 i_cfg_index,
    input  logic [dfr_pkg::CfgW-1:0]   i_cfg_wr_data,
    output dfr_pkg::t_result           o_result
);

    logic [15:0]               r_own_ship_id;
    logic [dfr_pkg::CntW-1:0]  r_timeout_ticks;
    dfr_pkg::t_link            r_link, n_link;
    dfr_pkg::t_mode            r_mode, n_mode;
    logic [dfr_pkg::IdxW-1:0]  r_exp_idx, n_exp_idx;
    logic [dfr_pkg::TotW-1:0]  r_total, n_total;
    logic [dfr_pkg::CntW-1:0]  r_count, n_count;
    logic                      r_running, n_running;

    logic [dfr_pkg::LenW-1:0]  len_clamped;
    logic [dfr_pkg::LenW-1:0]  len_data;
    logic [dfr_pkg::TotW:0]    add_sum;
    logic [dfr_pkg::TotW-1:0]  add_sat;
    logic [dfr_pkg::CntW-1:0]  limit;
    logic [dfr_pkg::CntW-1:0]  count_inc;
    dfr_pkg::t_event           ev;
    logic                      ack;
    logic                      complete;

    always_comb begin
        if (i_item.payload_len > dfr_pkg::LenW'(dfr_pkg::MaxPayloadBytes)) begin
            len_clamped = dfr_pkg::LenW'(dfr_pkg::MaxPayloadBytes);
        end else begin
            len_clamped = i_item.payload_len;
        end
        len_data = len_clamped - dfr_pkg::LenW'(1);
        add_sum = {1'b0, r_total} + (dfr_pkg::TotW+1)'(len_data);
        add_sat = add_sum[dfr_pkg::TotW] ? dfr_pkg::TotMax : add_sum[dfr_pkg::TotW-1:0];
        limit = (r_timeout_ticks == '0) ? dfr_pkg::CntW'(1) : r_timeout_ticks;
        count_inc = (r_count < dfr_pkg::CntMax) ? r_count + dfr_pkg::CntW'(1) : r_count;
    end

    always_comb begin
        n_link = r_link;
        n_mode = r_mode;
        n_exp_idx = r_exp_idx;
        n_total = r_total;
        n_count = r_count;
        n_running = r_running;
        ev = dfr_pkg::EV_NONE;
        ack = 1'b0;
        complete = 1'b0;

        if (i_item.req_type == dfr_pkg::ReqTick) begin
            if (r_running) begin
                n_count = count_inc;
                if (count_inc >= limit) begin
                    n_mode = dfr_pkg::MODE_IDLE;
                    n_exp_idx = '0;
                    n_total = '0;
                    n_count = '0;
                    n_running = 1'b0;
                    ev = dfr_pkg::EV_TIMEOUT;
                end
            end
        end else begin
            case (i_item.msg_type)
                dfr_pkg::MsgArm: begin
                    if (i_item.target_id == 16'd0 || i_item.target_id == 16'd1) begin
                        n_link = (i_item.target_id == 16'd0) ? dfr_pkg::LINK_BROADCAST
                                                             : dfr_pkg::LINK_DOWNLINK_ADDR;
                        n_mode = (i_item.target_id == 16'd0) ? dfr_pkg::MODE_BCAST
                                                             : dfr_pkg::MODE_UCAST;
                        n_exp_idx = '0;
                        n_total = '0;
                        n_count = '0;
                        n_running = 1'b1;
                    end else begin
                        ev = dfr_pkg::EV_IGNORED;
                    end
                end
                dfr_pkg::MsgFragStart, dfr_pkg::MsgFragCont, dfr_pkg::MsgFragEnd: begin
                    if (r_mode == dfr_pkg::MODE_IDLE) begin
                        ev = dfr_pkg::EV_IGNORED;
                    end else if (i_item.msg_type == dfr_pkg::MsgFragStart) begin
                        n_total = dfr_pkg::TotW'(len_clamped);
                        n_exp_idx = dfr_pkg::IdxW'(1);
                        n_count = '0;
                        n_running = 1'b1;
                        ev = dfr_pkg::EV_STARTED;
                    end else if (len_clamped == '0 ||
                                 dfr_pkg::IdxW'(i_item.first_byte) != r_exp_idx) begin
                        n_mode = dfr_pkg::MODE_IDLE;
                        n_exp_idx = '0;
                        n_total = '0;
                        n_count = '0;
                        n_running = 1'b0;
                        ev = (len_clamped == '0) ? dfr_pkg::EV_EMPTY : dfr_pkg::EV_SEQERR;
                    end else if (i_item.msg_type == dfr_pkg::MsgFragCont) begin
                        n_total = add_sat;
                        n_exp_idx = r_exp_idx + dfr_pkg::IdxW'(1);
                        n_count = '0;
                        n_running = 1'b1;
                        ev = dfr_pkg::EV_CONTINUED;
                    end else begin
                        ack = (r_mode == dfr_pkg::MODE_UCAST);
                        complete = 1'b1;
                        n_mode = dfr_pkg::MODE_IDLE;
                        n_exp_idx = '0;
                        n_total = '0;
                        n_count = '0;
                        n_running = 1'b0;
                        ev = dfr_pkg::EV_COMPLETE;
                    end
                end
                dfr_pkg::MsgPaging:   n_link = dfr_pkg::LINK_PAGING;
                dfr_pkg::MsgSmsAck:   n_link = dfr_pkg::LINK_SMS_ACK;
                dfr_pkg::MsgSmsNoack: n_link = dfr_pkg::LINK_SMS_NOACK;
                default:              ev = dfr_pkg::EV_IGNORED;
            endcase
        end
    end

    always_comb begin
        o_result.link_state = n_link;
        o_result.receive_mode = n_mode;
        o_result.event_code = ev;
        o_result.send_ack = ack;
        o_result.ack_ship_id = ack ? r_own_ship_id : 16'd0;
        o_result.total_length = complete ? add_sat : n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ship_id <= '0;
            r_timeout_ticks <= dfr_pkg::TimeoutReset;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == dfr_pkg::CfgOwnShipId) begin
                r_own_ship_id <= i_cfg_wr_data;
            end else begin
                r_timeout_ticks <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= dfr_pkg::LINK_UPLINK_ADDR;
            r_mode <= dfr_pkg::MODE_IDLE;
            r_exp_idx <= '0;
            r_total <= '0;
            r_count <= '0;
            r_running <= 1'b0;
        end else if (i_fire) begin
            r_link <= n_link;
            r_mode <= n_mode;
            r_exp_idx <= n_exp_idx;
            r_total <= n_total;
            r_count <= n_count;
            r_running <= n_running;
        end
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dfr_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int LongHold = 300;
    localparam int PhaseItems = 330;

    typedef struct packed {
        t_item   it;
        logic    typed;
        t_result res;
    } t_script_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [InDataW-1:0]    s_axis_tdata = '0;
    logic [InUserW-1:0]    s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OutDataW-1:0]   m_axis_tdata;
    logic                  i_cfg_wr_en = 1'b0;
    logic [0:0]            i_cfg_index = '0;
    logic [CfgW-1:0]       i_cfg_wr_data = '0;

    // Receiver state as the block should hold it.
    logic [2:0]  rx_link;
    logic [1:0]  rx_mode;
    logic [8:0]  rx_expect;
    logic [15:0] rx_total;
    logic [15:0] rx_count;
    logic        rx_timer_on;
    logic [15:0] rx_own_id;
    logic [15:0] rx_timeout;

    t_result     pending_reports[$];
    t_script_row script[$];
    int          items_sent = 0;
    int          fail_count = 0;
    bit          no_gaps = 1'b0;
    bit          hold_request = 1'b0;

    downlink_fragment_receiver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_receiver();
        rx_mode = MODE_IDLE;
        rx_expect = '0;
        rx_total = '0;
        rx_count = '0;
        rx_timer_on = 1'b0;
    endfunction

    function automatic void add_bytes(logic [8:0] n);
        logic [16:0] sum;
        sum = {1'b0, rx_total} + {8'd0, n};
        rx_total = sum[16] ? TotMax : sum[15:0];
    endfunction

    function automatic t_result advance_receiver(t_item it);
        t_result    r;
        logic [8:0] len;
        logic [15:0] lim;
        logic [15:0] tot_out;
        logic [2:0] ev;
        logic       ack;
        logic       held;
        len = (it.payload_len > MaxPayloadBytes) ? 9'(MaxPayloadBytes) : it.payload_len;
        ev = EV_NONE;
        ack = 1'b0;
        held = 1'b0;
        tot_out = '0;
        if (it.req_type == ReqTick) begin
            if (rx_timer_on) begin
                lim = (rx_timeout == 16'd0) ? 16'd1 : rx_timeout;
                if (rx_count != CntMax) rx_count = rx_count + 16'd1;
                if (rx_count >= lim) begin
                    clear_receiver();
                    ev = EV_TIMEOUT;
                end
            end
        end else if (it.msg_type == MsgArm) begin
            if (it.target_id <= 16'd1) begin
                rx_link = (it.target_id == 16'd0) ? LINK_BROADCAST : LINK_DOWNLINK_ADDR;
                clear_receiver();
                rx_mode = (it.target_id == 16'd0) ? MODE_BCAST : MODE_UCAST;
                rx_timer_on = 1'b1;
            end else begin
                ev = EV_IGNORED;
            end
        end else if (it.msg_type == MsgFragStart || it.msg_type == MsgFragCont ||
                     it.msg_type == MsgFragEnd) begin
            if (rx_mode == MODE_IDLE) begin
                ev = EV_IGNORED;
            end else if (it.msg_type == MsgFragStart) begin
                rx_total = '0;
                add_bytes(len);
                rx_expect = 9'd1;
                rx_count = '0;
                rx_timer_on = 1'b1;
                ev = EV_STARTED;
            end else if (len == 9'd0) begin
                clear_receiver();
                ev = EV_EMPTY;
            end else if ({1'b0, it.first_byte} != rx_expect) begin
                clear_receiver();
                ev = EV_SEQERR;
            end else if (it.msg_type == MsgFragCont) begin
                add_bytes(len - 9'd1);
                rx_expect = rx_expect + 9'd1;
                rx_count = '0;
                rx_timer_on = 1'b1;
                ev = EV_CONTINUED;
            end else begin
                add_bytes(len - 9'd1);
                ack = (rx_mode == MODE_UCAST);
                tot_out = rx_total;
                held = 1'b1;
                clear_receiver();
                ev = EV_COMPLETE;
            end
        end else if (it.msg_type == MsgPaging) begin
            rx_link = LINK_PAGING;
        end else if (it.msg_type == MsgSmsAck) begin
            rx_link = LINK_SMS_ACK;
        end else if (it.msg_type == MsgSmsNoack) begin
            rx_link = LINK_SMS_NOACK;
        end else begin
            ev = EV_IGNORED;
        end
        if (!held) tot_out = rx_total;
        r.link_state = rx_link;
        r.receive_mode = rx_mode;
        r.event_code = ev;
        r.send_ack = ack;
        r.ack_ship_id = ack ? rx_own_id : 16'd0;
        r.total_length = tot_out;
        return r;
    endfunction

    function automatic t_item item_of(logic [0:0] req, logic [7:0] mt, logic [15:0] tg,
                                      logic [7:0] fb, logic [8:0] len);
        t_item it;
        it.req_type = req;
        it.msg_type = mt;
        it.target_id = tg;
        it.first_byte = fb;
        it.payload_len = len;
        return it;
    endfunction

    function automatic t_result report_of(logic [2:0] link, logic [1:0] mode, logic [2:0] ev,
                                          logic ack, logic [15:0] id, logic [15:0] tot);
        t_result r;
        r.link_state = link;
        r.receive_mode = mode;
        r.event_code = ev;
        r.send_ack = ack;
        r.ack_ship_id = id;
        r.total_length = tot;
        return r;
    endfunction

    function automatic void add_row(t_item it, logic typed, t_result res);
        t_script_row row;
        row.it = it;
        row.typed = typed;
        row.res = res;
        script.push_back(row);
    endfunction

    function automatic logic [8:0] rand_len();
        case ($urandom_range(0, 9))
            0: return 9'd0;
            1: return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(1, 256));
        endcase
    endfunction

    function automatic t_item random_item(logic [0:0] req);
        return item_of(req, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), rand_len());
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    task automatic check_report(logic [OutDataW-1:0] d);
        t_result want;
        if (pending_reports.size() == 0) begin
            fail_count++;
            $error("result item with no pending input item: %h", d);
        end else begin
            want = pending_reports.pop_front();
            compare_field("link_state", 16'(want.link_state), 16'(d[2:0]));
            compare_field("receive_mode", 16'(want.receive_mode), 16'(d[4:3]));
            compare_field("event_code", 16'(want.event_code), 16'(d[7:5]));
            compare_field("send_ack", 16'(want.send_ack), 16'(d[8]));
            compare_field("ack_ship_id", want.ack_ship_id, d[24:9]);
            compare_field("total_length", want.total_length, d[40:25]);
        end
    endtask

    task automatic send_item(t_item it, logic typed, t_result res);
        t_result r;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, it.payload_len, it.first_byte, it.target_id, it.msg_type};
        s_axis_tuser <= it.req_type;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        r = advance_receiver(it);
        pending_reports.push_back(typed ? res : r);
        items_sent++;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_config(logic [15:0] ship_id, logic [15:0] ticks);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CfgOwnShipId;
        i_cfg_wr_data <= ship_id;
        @(posedge i_clk);
        i_cfg_index <= CfgTimeoutTicks;
        i_cfg_wr_data <= ticks;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        rx_own_id = ship_id;
        rx_timeout = ticks;
    endtask

    // Arm, optional start, a run of continuations and an end fragment, with ticks and
    // the odd bad index mixed in. The long run walks the index past 255.
    task automatic send_fragment_train(bit long_run);
        t_item      it;
        int         count;
        bit         started;
        logic [8:0] idx;
        count = long_run ? 258 : $urandom_range(0, 6);
        started = long_run || ($urandom_range(0, 7) != 0);
        it = random_item(ReqMessage);
        it.msg_type = MsgArm;
        it.target_id = 16'($urandom_range(0, 1));
        send_item(it, 1'b0, '0);
        if (started) begin
            it = random_item(ReqMessage);
            it.msg_type = MsgFragStart;
            if (long_run) it.payload_len = 9'd256;
            send_item(it, 1'b0, '0);
        end
        idx = started ? 9'd1 : 9'd0;
        for (int k = 0; k <= count; k++) begin
            if (!long_run && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_item(random_item(ReqTick), 1'b0, '0);
            it = random_item(ReqMessage);
            it.msg_type = (k == count) ? MsgFragEnd : MsgFragCont;
            it.first_byte = idx[7:0];
            if (long_run) begin
                it.payload_len = 9'd256;
            end else if ($urandom_range(0, 19) == 0) begin
                it.first_byte = 8'($urandom_range(0, 255));
            end else if (it.payload_len == 9'd0 && $urandom_range(0, 2) != 0) begin
                it.payload_len = 9'd1;
            end
            send_item(it, 1'b0, '0);
            idx = idx + 9'd1;
        end
    endtask

    task automatic send_noise();
        t_item it;
        it = random_item(ReqMessage);
        case ($urandom_range(0, 4))
            0: it.req_type = ReqTick;
            1: ;
            2: begin
                case ($urandom_range(0, 2))
                    0: it.msg_type = MsgPaging;
                    1: it.msg_type = MsgSmsAck;
                    default: it.msg_type = MsgSmsNoack;
                endcase
            end
            3: it.msg_type = MsgArm;
            default: it.msg_type = 8'($urandom_range(MsgFragStart, MsgFragEnd));
        endcase
        send_item(it, 1'b0, '0);
    endtask

    initial begin
        int          phase_end;
        int          phase_start;
        bit          hold_done;
        logic [15:0] ship;
        logic [15:0] ticks;
        hold_done = 1'b0;
        rx_link = LINK_UPLINK_ADDR;
        clear_receiver();
        rx_own_id = '0;
        rx_timeout = TimeoutReset;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_config(16'hFFFF, 16'd3);

        add_row(item_of(ReqTick, 8'd0, 16'd0, 8'd0, 9'd0), 1'b1,
                report_of(LINK_UPLINK_ADDR, MODE_IDLE, EV_NONE, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, MsgFragCont, 16'd0, 8'd0, 9'd5), 1'b1,
                report_of(LINK_UPLINK_ADDR, MODE_IDLE, EV_IGNORED, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, 8'hFF, 16'hFFFF, 8'hFF, 9'h1FF), 1'b1,
                report_of(LINK_UPLINK_ADDR, MODE_IDLE, EV_IGNORED, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, 8'd0, 16'd0, 8'd0, 9'd0), 1'b1,
                report_of(LINK_UPLINK_ADDR, MODE_IDLE, EV_IGNORED, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, MsgArm, 16'd2, 8'd0, 9'd0), 1'b1,
                report_of(LINK_UPLINK_ADDR, MODE_IDLE, EV_IGNORED, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, MsgPaging, 16'd0, 8'd0, 9'd0), 1'b1,
                report_of(LINK_PAGING, MODE_IDLE, EV_NONE, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, MsgSmsAck, 16'd0, 8'd0, 9'd0), 1'b1,
                report_of(LINK_SMS_ACK, MODE_IDLE, EV_NONE, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, MsgSmsNoack, 16'd0, 8'd0, 9'd0), 1'b1,
                report_of(LINK_SMS_NOACK, MODE_IDLE, EV_NONE, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, MsgArm, 16'd1, 8'd0, 9'd0), 1'b1,
                report_of(LINK_DOWNLINK_ADDR, MODE_UCAST, EV_NONE, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, MsgFragStart, 16'd0, 8'd0, 9'h1FF), 1'b1,
                report_of(LINK_DOWNLINK_ADDR, MODE_UCAST, EV_STARTED, 1'b0, 16'd0, 16'd256));
        add_row(item_of(ReqMessage, MsgFragCont, 16'd0, 8'd1, 9'd256), 1'b0, '0);
        add_row(item_of(ReqMessage, MsgFragCont, 16'd0, 8'd2, 9'd1), 1'b0, '0);
        add_row(item_of(ReqMessage, MsgFragEnd, 16'd0, 8'd3, 9'd256), 1'b0, '0);
        add_row(item_of(ReqMessage, MsgArm, 16'd0, 8'd0, 9'd0), 1'b1,
                report_of(LINK_BROADCAST, MODE_BCAST, EV_NONE, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, MsgFragCont, 16'd0, 8'd0, 9'd3), 1'b0, '0);
        add_row(item_of(ReqMessage, MsgFragEnd, 16'd0, 8'd9, 9'd4), 1'b1,
                report_of(LINK_BROADCAST, MODE_IDLE, EV_SEQERR, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, MsgArm, 16'd1, 8'd0, 9'd0), 1'b0, '0);
        add_row(item_of(ReqMessage, MsgFragStart, 16'd0, 8'd0, 9'd0), 1'b1,
                report_of(LINK_DOWNLINK_ADDR, MODE_UCAST, EV_STARTED, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, MsgFragEnd, 16'd0, 8'd1, 9'd0), 1'b1,
                report_of(LINK_DOWNLINK_ADDR, MODE_IDLE, EV_EMPTY, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, MsgArm, 16'd0, 8'd0, 9'd0), 1'b0, '0);
        add_row(item_of(ReqTick, 8'd0, 16'd0, 8'd0, 9'd0), 1'b0, '0);
        add_row(item_of(ReqTick, 8'd0, 16'd0, 8'd0, 9'd0), 1'b0, '0);
        add_row(item_of(ReqTick, 8'd0, 16'd0, 8'd0, 9'd0), 1'b1,
                report_of(LINK_BROADCAST, MODE_IDLE, EV_TIMEOUT, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqTick, 8'd0, 16'd0, 8'd0, 9'd0), 1'b1,
                report_of(LINK_BROADCAST, MODE_IDLE, EV_NONE, 1'b0, 16'd0, 16'd0));
        add_row(item_of(ReqMessage, MsgArm, 16'd1, 8'd0, 9'd0), 1'b0, '0);
        add_row(item_of(ReqMessage, MsgFragStart, 16'd0, 8'd0, 9'd10), 1'b0, '0);
        add_row(item_of(ReqMessage, MsgFragEnd, 16'd0, 8'd1, 9'd1), 1'b1,
                report_of(LINK_DOWNLINK_ADDR, MODE_IDLE, EV_COMPLETE, 1'b1, 16'hFFFF, 16'd10));
        for (int r = 0; r < script.size(); r++)
            send_item(script[r].it, script[r].typed, script[r].res);

        for (int p = 0; p < 6; p++) begin
            drain();
            ship = 16'($urandom_range(0, 65535));
            case (p)
                0: begin
                    ship = 16'd0;
                    ticks = 16'd1;
                end
                1: begin
                    ship = 16'hFFFF;
                    ticks = 16'hFFFF;
                end
                2: ticks = 16'($urandom_range(2, 40));
                3: ticks = TimeoutReset;
                4: ticks = 16'($urandom_range(1, 20));
                default: ticks = 16'($urandom_range(1, 65535));
            endcase
            write_config(ship, ticks);
            no_gaps = (p == 2 || p == 5);
            phase_start = items_sent;
            phase_end = items_sent + PhaseItems;
            if (p == 1) send_fragment_train(1'b1);
            while (items_sent < phase_end) begin
                if (p == 0 && !hold_done && items_sent > phase_start + 60) begin
                    hold_request = 1'b1;
                    hold_done = 1'b1;
                end
                if ($urandom_range(0, 9) < 7)
                    send_fragment_train(1'b0);
                else
                    send_noise();
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        int stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                stall = LongHold;
                hold_request = 1'b0;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 12);
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            check_report(m_axis_tdata);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WatchdogLimit) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
                (m_axis_tready && m_axis_tvalid === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dfr_pkg.sv
rtl/dfr_core.sv
rtl/downlink_fragment_receiver.sv
verif/testbench.sv
